// ===== sv/tcs_pkg.sv =====
package tcs_pkg;

    // Geometry of the history ring and the viewport
    localparam int HIST_LINES     = 1024;
    localparam int LINE_WIDTH     = 80;
    localparam int VIEW_ROWS      = 18;
    localparam int VIEW_FIRST_ROW = 3;

    localparam int LINE_W  = $clog2(HIST_LINES);
    localparam int COL_W   = $clog2(LINE_WIDTH);
    localparam int ROW_W   = $clog2(VIEW_ROWS + 1);
    localparam int OP_W    = 2;
    localparam int CODE_W  = 8;
    localparam int COLOR_W = 8;
    localparam int VAL_W   = 16;
    localparam int ADDR_W  = 17;
    localparam int POS_W   = 11;

    // Small queues between the stages
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1) + 1;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
    localparam logic [OP_W-1:0] OP_UP   = 2'd1;
    localparam logic [OP_W-1:0] OP_DOWN = 2'd2;
    localparam logic [OP_W-1:0] OP_ADV  = 2'd3;

    // Control characters
    localparam logic [CODE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
    localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
    localparam int TAB_STEP = 4;

    // Classified request kinds
    localparam logic [2:0] CLS_PRINT = 3'd0;
    localparam logic [2:0] CLS_NL    = 3'd1;
    localparam logic [2:0] CLS_CR    = 3'd2;
    localparam logic [2:0] CLS_BS    = 3'd3;
    localparam logic [2:0] CLS_TAB   = 3'd4;
    localparam logic [2:0] CLS_UP    = 3'd5;
    localparam logic [2:0] CLS_DOWN  = 3'd6;
    localparam logic [2:0] CLS_ADV   = 3'd7;

    typedef struct packed {
        logic [2:0]        cls;
        logic [CODE_W-1:0] code;
    } t_cmd;

    // Result before address and cursor products are formed
    typedef struct packed {
        logic              wr;
        logic [LINE_W-1:0] wline;
        logic [COL_W-1:0]  wcol;
        logic [VAL_W-1:0]  val;
        logic [LINE_W-1:0] top;
        logic [LINE_W-1:0] line;
        logic              vis;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              follow;
        logic              refresh;
    } t_raw;

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  val;
        logic [LINE_W-1:0] top;
        logic [LINE_W-1:0] line;
        logic              vis;
        logic [POS_W-1:0]  pos;
        logic              follow;
        logic              refresh;
    } t_res;

    function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] l);
        return (l == LINE_W'(HIST_LINES - 1)) ? '0 : l + 1'b1;
    endfunction

    function automatic logic [LINE_W-1:0] line_dec(input logic [LINE_W-1:0] l);
        return (l == '0) ? LINE_W'(HIST_LINES - 1) : l - 1'b1;
    endfunction

    // Top line that puts line l on the bottom viewport row
    function automatic logic [LINE_W-1:0] bottom_of(input logic [LINE_W-1:0] l);
        return (l >= LINE_W'(VIEW_ROWS - 1)) ? l - LINE_W'(VIEW_ROWS - 1)
                                             : LINE_W'(32'(l) + HIST_LINES - (VIEW_ROWS - 1));
    endfunction

endpackage

// ===== sv/tcs_front.sv =====
module tcs_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [tcs_pkg::OP_W-1:0]   i_op,
    input  logic [tcs_pkg::CODE_W-1:0] i_code,
    output logic                       o_full,
    output logic                       o_valid,
    output tcs_pkg::t_cmd              o_cmd,
    input  logic                       i_take
);
    import tcs_pkg::*;

    t_cmd              r_q [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_CW-1:0]   r_cnt;
    logic [Q_CW-1:0]   n_cnt;
    t_cmd              cmd_in;
    logic              push_ok;
    logic              take_ok;

    always_comb begin
        cmd_in.code = i_code;
        unique case (i_op)
            OP_CHAR: begin
                unique case (i_code)
                    CH_NL:   cmd_in.cls = CLS_NL;
                    CH_CR:   cmd_in.cls = CLS_CR;
                    CH_BS:   cmd_in.cls = CLS_BS;
                    CH_TAB:  cmd_in.cls = CLS_TAB;
                    default: cmd_in.cls = CLS_PRINT;
                endcase
            end
            OP_UP:   cmd_in.cls = CLS_UP;
            OP_DOWN: cmd_in.cls = CLS_DOWN;
            OP_ADV:  cmd_in.cls = CLS_ADV;
            default: cmd_in.cls = CLS_ADV;
        endcase
    end

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign take_ok = i_take && o_valid;
    assign n_cnt   = r_cnt + Q_CW'(push_ok) - Q_CW'(take_ok);

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (take_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== sv/tcs_back.sv =====
module tcs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  tcs_pkg::t_cmd               i_cmd,
    output logic                        o_take,
    input  logic [tcs_pkg::COLOR_W-1:0] i_color,
    output logic                        o_empty,
    output tcs_pkg::t_res               o_res,
    input  logic                        i_pop
);
    import tcs_pkg::*;

    // Console state
    logic [COL_W-1:0]  r_col;
    logic [LINE_W-1:0] r_line;
    logic [LINE_W-1:0] r_top;
    logic              r_follow;
    logic [COL_W-1:0]  n_col;
    logic [LINE_W-1:0] n_line;
    logic [LINE_W-1:0] n_top;
    logic              n_follow;

    logic [COL_W:0]    col_ext;
    logic [COL_W:0]    col_nx;
    logic              is_char;
    logic              line_step;
    logic [LINE_W-1:0] line_mid;
    logic [LINE_W-1:0] bot_now;
    logic [LINE_W:0]   diff_ext;
    logic [LINE_W-1:0] diff;
    logic [CODE_W-1:0] wcode;
    t_raw              raw;

    t_raw              r_pipe;
    logic              r_pv;
    t_res              res_b;

    t_res              r_oq [Q_DEPTH];
    logic [Q_AW-1:0]   r_owp;
    logic [Q_AW-1:0]   r_orp;
    logic [Q_CW-1:0]   r_ocnt;
    logic              pop_ok;

    assign col_ext = {1'b0, r_col};
    assign bot_now = bottom_of(r_line);

    always_comb begin
        col_nx     = col_ext;
        is_char    = 1'b0;
        line_step  = 1'b0;
        n_top      = r_top;
        n_follow   = r_follow;
        raw.wr     = 1'b0;
        raw.wline  = r_line;
        raw.wcol   = r_col;
        raw.refresh = 1'b1;
        wcode      = i_cmd.code;

        case (i_cmd.cls)
            CLS_PRINT: begin
                is_char = 1'b1;
                raw.wr  = 1'b1;
                col_nx  = col_ext + 1'b1;
            end
            CLS_NL: begin
                is_char   = 1'b1;
                col_nx    = '0;
                line_step = 1'b1;
            end
            CLS_CR: begin
                is_char = 1'b1;
                col_nx  = '0;
            end
            CLS_BS: begin
                is_char = 1'b1;
                if (r_col != '0) begin
                    col_nx   = col_ext - 1'b1;
                    raw.wr   = 1'b1;
                    raw.wcol = r_col - 1'b1;
                    wcode    = CH_SPACE;
                end
            end
            CLS_TAB: begin
                is_char = 1'b1;
                col_nx  = (col_ext + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
            end
            CLS_UP: begin
                n_top    = line_dec(r_top);
                n_follow = 1'b0;
            end
            CLS_DOWN: begin
                if (r_top == bot_now) begin
                    n_follow    = 1'b1;
                    raw.refresh = 1'b0;
                end else begin
                    n_top = line_inc(r_top);
                    if (line_inc(r_top) == bot_now) begin
                        n_follow = 1'b1;
                    end
                end
            end
            default: begin
                line_step = 1'b1;
            end
        endcase

        // column wrap into the next line
        if (is_char && col_nx >= (COL_W+1)'(LINE_WIDTH)) begin
            col_nx    = '0;
            line_step = 1'b1;
        end
        n_col    = col_nx[COL_W-1:0];
        line_mid = line_step ? line_inc(r_line) : r_line;
        n_line   = line_mid;
        if ((is_char || i_cmd.cls == CLS_ADV) && r_follow) begin
            n_top = bottom_of(line_mid);
        end

        diff_ext = (n_line >= n_top) ? {1'b0, n_line} - {1'b0, n_top}
                                     : (LINE_W+1)'(32'(n_line) + HIST_LINES - 32'(n_top));
        diff     = diff_ext[LINE_W-1:0];

        raw.val    = raw.wr ? {i_color, wcode} : '0;
        raw.top    = n_top;
        raw.line   = n_line;
        raw.vis    = (diff < LINE_W'(VIEW_ROWS));
        raw.row    = diff[ROW_W-1:0];
        raw.col    = n_col;
        raw.follow = n_follow;
    end

    // Take a request only when the result queue can absorb it
    assign o_take = i_valid && ((r_ocnt + Q_CW'(r_pv)) < Q_CW'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_line   <= '0;
            r_top    <= '0;
            r_follow <= 1'b1;
            r_pv     <= 1'b0;
        end else begin
            r_pv <= o_take;
            if (o_take) begin
                r_col    <= n_col;
                r_line   <= n_line;
                r_top    <= n_top;
                r_follow <= n_follow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_pipe <= raw;
        end
    end

    // Address and cursor products
    always_comb begin
        res_b.wr      = r_pipe.wr;
        res_b.addr    = r_pipe.wr ? ADDR_W'(ADDR_W'(r_pipe.wline) * ADDR_W'(LINE_WIDTH)
                                            + ADDR_W'(r_pipe.wcol))
                                  : '0;
        res_b.val     = r_pipe.val;
        res_b.top     = r_pipe.top;
        res_b.line    = r_pipe.line;
        res_b.vis     = r_pipe.vis;
        res_b.pos     = r_pipe.vis ? POS_W'((POS_W'(VIEW_FIRST_ROW) + POS_W'(r_pipe.row))
                                            * POS_W'(LINE_WIDTH) + POS_W'(r_pipe.col))
                                   : '0;
        res_b.follow  = r_pipe.follow;
        res_b.refresh = r_pipe.refresh;
    end

    assign o_empty = (r_ocnt == '0);
    assign o_res   = r_oq[r_orp];
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_oq[r_owp] <= res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_pv) begin
                r_owp <= r_owp + 1'b1;
            end
            if (pop_ok) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= r_ocnt + Q_CW'(r_pv) - Q_CW'(pop_ok);
        end
    end

endmodule

// ===== sv/text_console_scrollback_core.sv =====
// Text console scrollback core. Push one request per cycle (a character, a
// view scroll-up, a view scroll-down or a line advance); each yields exactly
// one result, in order, holding the history cell write, the view top, the
// write line, the visible cursor position and the follow/refresh flags.
// Sustained rate is one request per cycle, set by the console state update
// in the back stage, while the result queue has room. A result reaches the
// result ports via the input queue, the state update register and the
// result queue, which takes the address and cursor products. Set
// text_color over the register port at address 0 while no request is in
// flight. The history memory is written from the result ports by its owner.
module text_console_scrollback_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [tcs_pkg::OP_W-1:0]     i_op,
    input  logic [tcs_pkg::CODE_W-1:0]   i_char_code,
    output logic                         empty,
    input  logic                         pop,
    output logic                         o_cell_write,
    output logic [tcs_pkg::ADDR_W-1:0]   o_cell_addr,
    output logic [tcs_pkg::VAL_W-1:0]    o_cell_value,
    output logic [tcs_pkg::LINE_W-1:0]   o_view_top,
    output logic [tcs_pkg::LINE_W-1:0]   o_write_line,
    output logic                         o_cursor_visible,
    output logic [tcs_pkg::POS_W-1:0]    o_cursor_pos,
    output logic                         o_auto_follow,
    output logic                         o_refresh,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tcs_pkg::*;

    localparam logic REG_TEXT_COLOR = 1'b0;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;

    logic [COLOR_W-1:0] r_color;
    logic               cmd_valid;
    t_cmd               cmd;
    logic               cmd_take;
    t_res               res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TEXT_COLOR) ? 32'(r_color) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_TEXT_COLOR) begin
            r_color <= pwdata[COLOR_W-1:0];
        end
    end

    tcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (i_op),
        .i_code  (i_char_code),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (cmd),
        .i_take  (cmd_take)
    );

    tcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cmd_valid),
        .i_cmd   (cmd),
        .o_take  (cmd_take),
        .i_color (r_color),
        .o_empty (empty),
        .o_res   (res),
        .i_pop   (pop)
    );

    assign o_cell_write     = res.wr;
    assign o_cell_addr      = res.addr;
    assign o_cell_value     = res.val;
    assign o_view_top       = res.top;
    assign o_write_line     = res.line;
    assign o_cursor_visible = res.vis;
    assign o_cursor_pos     = res.pos;
    assign o_auto_follow    = res.follow;
    assign o_refresh        = res.refresh;

endmodule
